// ===== rtl/iphc_pkg.sv =====
package iphc_pkg;

    localparam int ADC_BITS_DEF = 12;

    localparam int SOIL_W   = 12;
    localparam int SOIL_DRY = 4095;
    localparam int SOIL_WET = 1500;

    // (SOIL_DRY - x) * 100 / 2595 == ((SOIL_DRY - x) * PCT_RECIP) >> PCT_SHIFT
    // for every difference in 0..2595
    localparam int PCT_W     = 7;
    localparam int PCT_RECIP = 161631;
    localparam int RECIP_W   = 18;
    localparam int PCT_SHIFT = 22;
    localparam int PROD_W    = SOIL_W + RECIP_W;

    localparam int CNT_W     = 16;

    localparam logic [PCT_W-1:0] MIN_RST      = 7'd30;
    localparam logic [PCT_W-1:0] MAX_RST      = 7'd40;
    localparam logic [CNT_W-1:0] DURATION_RST = 16'd1000;
    localparam logic [CNT_W-1:0] COOLDOWN_RST = 16'd15000;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [1:0] {
        REG_MIN_MOISTURE = 2'd0,
        REG_MAX_MOISTURE = 2'd1,
        REG_DURATION     = 2'd2,
        REG_COOLDOWN     = 2'd3
    } t_reg_idx;

endpackage

// ===== rtl/irrigation_pump_hysteresis_control_unit.sv =====
// An accepted input item passes the input register, then the result register.
// Throughput: one item per cycle unless the output stalls; single registered state update.
// Backpressure: the input stage refills in the cycle its item moves to the result register.
// Reset: synchronous, active low; clears all control and watering state and loads
// the register defaults (min 30, max 40, duration 1000, cooldown 15000).
module irrigation_pump_hysteresis_control_unit #(
    parameter int ADC_BITS = iphc_pkg::ADC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [ADC_BITS-1:0] soil_raw, [ADC_BITS] rain_level, rest zero
    input  logic [((ADC_BITS+8)/8)*8-1:0]       s_axis_tdata,
    // [0] mode
    input  logic                                s_axis_tuser,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] pump_on, [7:1] moisture_percent, [8] manual_running,
    // [9] request_accepted, rest zero
    output logic [iphc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [iphc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [iphc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [iphc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import iphc_pkg::*;

    logic [PCT_W-1:0]    r_min;
    logic [PCT_W-1:0]    r_max;
    logic [CNT_W-1:0]    r_duration;
    logic [CNT_W-1:0]    r_cooldown;

    logic                r_in_valid;
    logic                r_in_mode;
    logic [ADC_BITS-1:0] r_in_soil;
    logic                r_in_rain;

    logic                r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic                r_auto;
    logic                r_manual;
    logic [CNT_W-1:0]    r_remaining;
    logic                r_ever;
    logic [CNT_W-1:0]    r_since;
    logic                r_pump;

    logic                n_auto;
    logic                n_manual;
    logic [CNT_W-1:0]    n_remaining;
    logic                n_ever;
    logic [CNT_W-1:0]    n_since;
    logic                n_pump;
    logic                n_accepted;
    logic [CNT_W-1:0]    w_rem_dec;

    logic [PCT_W-1:0]    w_pct;
    logic                w_raining;
    logic                w_advance;
    logic                w_cfg_wr;
    t_reg_idx            w_idx;

    iphc_pct_map #(
        .ADC_BITS (ADC_BITS)
    ) u_pct_map (
        .i_soil_raw (r_in_soil),
        .o_pct      (w_pct)
    );

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign pready   = 1'b1;
    assign w_idx    = t_reg_idx'(paddr[3:2]);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (w_idx)
            REG_MIN_MOISTURE: prdata = APB_DATA_W'(r_min);
            REG_MAX_MOISTURE: prdata = APB_DATA_W'(r_max);
            REG_DURATION:     prdata = APB_DATA_W'(r_duration);
            REG_COOLDOWN:     prdata = APB_DATA_W'(r_cooldown);
            default:          prdata = '0;
        endcase
    end

    assign w_raining = !r_in_rain;
    assign w_rem_dec = (r_remaining != '0) ? r_remaining - CNT_W'(1) : '0;

    always_comb begin
        n_auto      = r_auto;
        n_manual    = r_manual;
        n_remaining = r_remaining;
        n_ever      = r_ever;
        n_since     = r_since;
        n_pump      = r_pump;
        n_accepted  = 1'b0;
        if (r_in_mode) begin
            if (!r_ever || (r_since >= r_cooldown)) begin
                n_accepted  = 1'b1;
                n_ever      = 1'b1;
                n_since     = '0;
                n_manual    = 1'b1;
                n_remaining = r_duration;
            end
        end else begin
            if (r_since < r_cooldown) begin
                n_since = r_since + CNT_W'(1);
            end
            if (r_manual) begin
                n_remaining = w_rem_dec;
                if (w_rem_dec != '0) begin
                    n_pump = 1'b1;
                end else begin
                    n_manual = 1'b0;
                    n_pump   = 1'b0;
                end
            end else begin
                priority if ((w_pct <= r_min) && !w_raining) begin
                    n_auto = 1'b1;
                end else if ((w_pct >= r_max) || w_raining) begin
                    n_auto = 1'b0;
                end
                n_pump = n_auto;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min       <= MIN_RST;
            r_max       <= MAX_RST;
            r_duration  <= DURATION_RST;
            r_cooldown  <= COOLDOWN_RST;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_auto      <= 1'b0;
            r_manual    <= 1'b0;
            r_remaining <= '0;
            r_ever      <= 1'b0;
            r_since     <= '0;
            r_pump      <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                unique case (w_idx)
                    REG_MIN_MOISTURE: r_min      <= pwdata[PCT_W-1:0];
                    REG_MAX_MOISTURE: r_max      <= pwdata[PCT_W-1:0];
                    REG_DURATION:     r_duration <= pwdata[CNT_W-1:0];
                    REG_COOLDOWN:     r_cooldown <= pwdata[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_auto      <= n_auto;
                r_manual    <= n_manual;
                r_remaining <= n_remaining;
                r_ever      <= n_ever;
                r_since     <= n_since;
                r_pump      <= n_pump;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_mode <= s_axis_tuser;
            r_in_soil <= s_axis_tdata[ADC_BITS-1:0];
            r_in_rain <= s_axis_tdata[ADC_BITS];
        end
        if (w_advance) begin
            r_out_data <= OUT_TDATA_W'({n_accepted, n_manual, w_pct, n_pump});
        end
    end

endmodule

// ===== rtl/iphc_pct_map.sv =====
module iphc_pct_map #(
    parameter int ADC_BITS = iphc_pkg::ADC_BITS_DEF
) (
    input  logic [ADC_BITS-1:0]         i_soil_raw,
    output logic [iphc_pkg::PCT_W-1:0]  o_pct
);
    import iphc_pkg::*;

    logic [ADC_BITS-1:0] w_clamped;
    logic [SOIL_W-1:0]   w_diff;
    logic [PROD_W-1:0]   w_prod;

    always_comb begin
        if (i_soil_raw > ADC_BITS'(SOIL_DRY)) begin
            w_clamped = ADC_BITS'(SOIL_DRY);
        end else if (i_soil_raw < ADC_BITS'(SOIL_WET)) begin
            w_clamped = ADC_BITS'(SOIL_WET);
        end else begin
            w_clamped = i_soil_raw;
        end
    end

    assign w_diff = SOIL_W'(SOIL_DRY) - w_clamped[SOIL_W-1:0];
    assign w_prod = PROD_W'(w_diff) * PROD_W'(PCT_RECIP);
    assign o_pct  = w_prod[PCT_SHIFT +: PCT_W];

endmodule

// ===== rtl/iphc_chk.sv =====
module iphc_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [iphc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import iphc_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:1] <= 7'd100)
        else $error("moisture percent above 100");

    a_accept_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[8])
        else $error("accepted request without a manual run");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:10] == '0)
        else $error("nonzero padding in result");

endmodule

bind irrigation_pump_hysteresis_control_unit iphc_chk u_iphc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
